// File: src/kvcm_pkg.sv
// Package: shared types and constants of the keyed value cache match block
`default_nettype none
package kvcm_pkg;

	localparam int unsigned POS_W = 7;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_LONG = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// Broadcast to every cell for one accepted request
	typedef struct packed {
		logic             step;
		logic             last;
		logic             commit;
		logic [POS_W-1:0] pos;
		logic [7:0]       data;
		logic [7:0]       opcode;
		logic [7:0]       ext_opcode;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: src/kvcm_cell.sv
// Cell: one table entry with its byte compare and registered hit flag
`default_nettype none
module kvcm_cell #(
	parameter int unsigned MAX_BYTES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kvcm_pkg::cell_ctl_t ctl,
	input  wire logic              sel,
	output logic                   hit_q
);
	localparam int unsigned BW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int unsigned LW = $clog2(MAX_BYTES + 1);

	logic [7:0]    bytes_q [2**BW];
	logic [LW-1:0] len_q;
	logic [7:0]    op_q;
	logic [7:0]    ext_q;
	logic          mism_q;

	logic [BW-1:0] bi;
	logic          in_range;
	logic          bad;
	logic [LW-1:0] new_len;
	logic          key_ok;

	// Compare the incoming byte against this entry's byte at the same place
	always_comb begin
		bi       = ctl.pos[BW-1:0];
		in_range = (ctl.pos < kvcm_pkg::POS_W'(MAX_BYTES));
		bad      = in_range && (bytes_q[bi] != ctl.data);
		new_len  = LW'(ctl.pos + kvcm_pkg::POS_W'(1));
		key_ok   = (len_q == new_len) && (op_q == ctl.opcode)
			&& ((ext_q == ctl.ext_opcode) || (ext_q == 8'd0));
	end

	// Hold mismatch across the string, latch hit on the closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mism_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				mism_q <= 1'b0;
				hit_q  <= !(mism_q || bad) && key_ok;
			end else begin
				mism_q <= mism_q || bad;
			end
		end
	end

	// Store bytes and keys when this cell is the next free entry
	always_ff @(posedge clk) begin
		if (ctl.step && sel) begin
			if (in_range) begin
				bytes_q[bi] <= ctl.data;
			end
			if (ctl.last && ctl.commit) begin
				len_q <= new_len;
				op_q  <= ctl.opcode;
				ext_q <= ctl.ext_opcode;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/keyed_value_cache_match.sv
// Top level: staging control, row of entry cells and lowest-hit scanner
//
//  channel | signals                                        | dir
//  in      | in_valid, in_stall, kind, opcode, ext_opcode,   | in
//          | data_byte, last                                |
//  out     | out_valid, out_stall, status, index            | out
//
// Non-closing bytes give no result.
// An insert or an overlong string answers in the cycle after its closing byte.
// A lookup answers once the scanner has walked the cells' hit flags, eight
// entries a cycle, up to the group with the lowest hit or the last group.
// Input stalls while a lookup scans or a result waits. Reset empties the table.
`default_nettype none
module keyed_value_cache_match #(
	parameter int unsigned ENTRIES   = 64,
	parameter int unsigned MAX_BYTES = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       kind,
	input  wire logic [7:0] opcode,
	input  wire logic [7:0] ext_opcode,
	input  wire logic [7:0] data_byte,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [5:0]      index
);
	localparam int unsigned CW  = $clog2(ENTRIES + 1);
	localparam int unsigned IW  = $clog2(ENTRIES);
	localparam int unsigned NG  = (ENTRIES + 7) / 8;
	localparam int unsigned GW  = (NG > 1) ? $clog2(NG) : 1;
	localparam int unsigned PAD = NG * 8;

	kvcm_pkg::state_t    state_q, state_d;
	kvcm_pkg::cell_ctl_t ctl;
	logic [CW-1:0]       count_q;
	logic [kvcm_pkg::POS_W-1:0] pos_q;
	logic                long_q;
	logic [GW-1:0]       grp_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [IW-1:0]       index_q;

	logic                acc;
	logic                at_max;
	logic                is_long;
	logic                full;
	logic                commit;
	logic [ENTRIES-1:0]  sel;
	logic [ENTRIES-1:0]  hit;
	logic [PAD-1:0]      hit_pad;
	logic [7:0]          grp_hits;
	logic                grp_found;
	logic [2:0]          grp_off;

	assign in_stall  = (state_q != kvcm_pkg::S_IDLE) || out_valid_q;
	assign acc       = in_valid && !in_stall;
	assign at_max    = (pos_q == kvcm_pkg::POS_W'(MAX_BYTES));
	assign is_long   = long_q || at_max;
	assign full      = (count_q == CW'(ENTRIES));
	assign commit    = !is_long && !kind && !full;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign index     = 6'(index_q);

	// Broadcast the request to the cells
	always_comb begin
		ctl.step       = acc;
		ctl.last       = last;
		ctl.commit     = commit;
		ctl.pos        = pos_q;
		ctl.data       = data_byte;
		ctl.opcode     = opcode;
		ctl.ext_opcode = ext_opcode;
	end

	// Row of entry cells; a hit counts only for a stored entry
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic raw_hit;
		assign sel[i] = (count_q == CW'(i));
		kvcm_cell #(.MAX_BYTES(MAX_BYTES)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (sel[i]),
			.hit_q  (raw_hit)
		);
		assign hit[i] = raw_hit && (CW'(i) < count_q);
	end

	assign hit_pad = PAD'(hit);

	// Pick the lowest hit inside the current group of eight
	always_comb begin
		grp_hits  = hit_pad[grp_q*8 +: 8];
		grp_found = 1'b0;
		grp_off   = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (grp_hits[k]) begin
				grp_found = 1'b1;
				grp_off   = 3'(k);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvcm_pkg::S_IDLE: begin
				if (acc && last && !is_long && kind) begin
					state_d = kvcm_pkg::S_SCAN;
				end
			end
			kvcm_pkg::S_SCAN: begin
				if (grp_found || (grp_q == GW'(NG - 1))) begin
					state_d = kvcm_pkg::S_IDLE;
				end
			end
			default: state_d = kvcm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvcm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance staging, entry count, scan group and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pos_q       <= '0;
			long_q      <= 1'b0;
			grp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (acc) begin
				if (last) begin
					pos_q  <= '0;
					long_q <= 1'b0;
					grp_q  <= '0;
					if (commit) begin
						count_q <= count_q + CW'(1);
					end
					if (is_long || !kind) begin
						out_valid_q <= 1'b1;
					end
				end else begin
					long_q <= is_long;
					if (!at_max) begin
						pos_q <= pos_q + kvcm_pkg::POS_W'(1);
					end
				end
			end
			if (state_q == kvcm_pkg::S_SCAN) begin
				grp_q <= grp_q + GW'(1);
				if (grp_found || (grp_q == GW'(NG - 1))) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Result payload; a lookup starts as a miss until the scan finishes
	always_ff @(posedge clk) begin
		if (acc && last) begin
			index_q <= '0;
			priority if (is_long) begin
				status_q <= kvcm_pkg::ST_LONG;
			end else if (!kind && full) begin
				status_q <= kvcm_pkg::ST_FULL;
			end else if (!kind) begin
				status_q <= kvcm_pkg::ST_OK;
				index_q  <= IW'(count_q);
			end else begin
				status_q <= kvcm_pkg::ST_MISS;
			end
		end else if (state_q == kvcm_pkg::S_SCAN) begin
			if (grp_found) begin
				status_q <= kvcm_pkg::ST_OK;
				index_q  <= IW'({grp_q, grp_off});
			end else begin
				status_q <= kvcm_pkg::ST_MISS;
				index_q  <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/kvcm_checker.sv
// Checker: port-level properties of the keyed value cache match block
`default_nettype none
module kvcm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [1:0] status,
	input wire logic [5:0] index
);
	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(index))
		else $error("stalled result changed");

	// A failed request reports index zero
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != kvcm_pkg::ST_OK) |-> index == 6'd0)
		else $error("nonzero index with failing status");

	// Stall input while a result waits
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// A non-closing byte raises no result
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last |=> !$rose(out_valid))
		else $error("result after non-closing byte");

endmodule

bind keyed_value_cache_match kvcm_checker u_kvcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last      (last),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.index     (index)
);
`default_nettype wire
